// File: design/nel_pkg.sv
// Shared types and constants for the nearest edge line per side block.
package nel_pkg;

  localparam int IN_COORD_BITS = 12;
  localparam int OUT_COORD_BITS = 14;
  localparam int DIFF_BITS = 12;
  localparam int SQ_BITS = 2 * DIFF_BITS;
  localparam int DIST_BITS = SQ_BITS + 1;
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_INDEX_BITS = 2;
  localparam int OFFSET_BITS = 8;
  localparam int SIZE_BITS = 13;
  localparam int NUM_SIDES = 4;
  localparam int NUM_COORDS = 4;
  localparam int IN_TDATA_BITS = 48;
  localparam int OUT_TDATA_BITS = 56;
  localparam int OUT_TUSER_BITS = 3;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 13'd4096;
  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 8'd0;

  typedef enum logic [1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_BOTTOM = 2'd1,
    SIDE_LEFT   = 2'd2,
    SIDE_RIGHT  = 2'd3
  } side_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_OFFSET = 2'd2
  } cfg_index_t;

  typedef struct packed {
    side_t                side;
    logic [DIFF_BITS-1:0] ddx;
    logic [DIFF_BITS-1:0] ddy;
  } class_t;

endpackage

// File: design/nel_classify.sv
// Side classification and centre offsets of one line segment.
module nel_classify
  import nel_pkg::*;
#(
  parameter int CW = 12
) (
  input  logic [CW-1:0]        sx,
  input  logic [CW-1:0]        sy,
  input  logic [CW-1:0]        ex,
  input  logic [CW-1:0]        ey,
  input  logic [DIFF_BITS-1:0] cx,
  input  logic [DIFF_BITS-1:0] cy,
  output class_t               res
);

  logic [CW:0]          sum_x;
  logic [CW:0]          sum_y;
  logic [DIFF_BITS-1:0] mx;
  logic [DIFF_BITS-1:0] my;
  logic [CW-1:0]        adx;
  logic [CW-1:0]        ady;
  logic                 horiz;

  always_comb begin
    sum_x = (CW + 1)'(sx) + (CW + 1)'(ex);
    sum_y = (CW + 1)'(sy) + (CW + 1)'(ey);
    mx = DIFF_BITS'(sum_x[CW:1]);
    my = DIFF_BITS'(sum_y[CW:1]);
    adx = (sx >= ex) ? sx - ex : ex - sx;
    ady = (sy >= ey) ? sy - ey : ey - sy;
    // A segment with no horizontal extent is always steep.
    horiz = (adx != '0) && (ady <= adx);
    if (horiz) begin
      res.side = (my <= cy) ? SIDE_TOP : SIDE_BOTTOM;
    end else begin
      res.side = (mx <= cx) ? SIDE_LEFT : SIDE_RIGHT;
    end
    res.ddx = (mx >= cx) ? mx - cx : cx - mx;
    res.ddy = (my >= cy) ? my - cy : cy - my;
  end

endmodule

// File: design/nearest_edge_line_per_side_top.sv
// Top level of the nearest edge line per side block.
//
// Segments enter on the s_ stream, one request per segment, with s_tuser low;
// a request with s_tuser high marks the end of a frame. For every side class
// (top, bottom, left, right) the block keeps the segment whose midpoint is
// nearest the image centre. An end of frame request yields four results on
// the m_ stream in the order top, bottom, left, right, with tlast on the
// fourth, and then empties the store for the next frame.
// A new request is accepted every cycle, except while an end of frame waits
// in the update stage. A segment passes an input register, a stage that
// squares the centre offsets, and a compare and update stage. The four
// results are then copied to a result bank; the first goes to the output
// register, followed by one result per cycle while the receiver takes them.
// Segments of the next frame keep flowing while they drain; a second end of
// frame waits in the update stage until the bank is empty. When the receiver
// stalls, the output register holds its result; the pipeline backs up only
// while such an end of frame waits. Reset empties the store and returns the
// registers to width 4096, height 4096, offset 0.
module nearest_edge_line_per_side_top
  import nel_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // start_x, start_y, end_x, end_y, 12 bits each
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  // mode
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // out_start_x, out_start_y, out_end_x, out_end_y, 14 bits each
  output logic [OUT_TDATA_BITS-1:0] m_tdata,
  // side (2 bits), status
  output logic [OUT_TUSER_BITS-1:0] m_tuser,
  output logic                      m_tlast
);

  localparam int CW = (COORD_BITS < IN_COORD_BITS) ? COORD_BITS : IN_COORD_BITS;

  logic [SIZE_BITS-1:0]   image_width;
  logic [SIZE_BITS-1:0]   image_height;
  logic [OFFSET_BITS-1:0] side_offset;

  logic          p1_valid;
  logic          p1_eof;
  logic [CW-1:0] p1_seg [NUM_COORDS];

  logic               p2_valid;
  logic               p2_eof;
  side_t              p2_side;
  logic [SQ_BITS-1:0] p2_sqx;
  logic [SQ_BITS-1:0] p2_sqy;
  logic [CW-1:0]      p2_seg [NUM_COORDS];

  logic [NUM_SIDES-1:0] found;
  logic [DIST_BITS-1:0] best_dist [NUM_SIDES];
  logic [CW-1:0]        best_seg [NUM_SIDES][NUM_COORDS];

  logic                 snap_busy;
  logic [1:0]           side_cnt;
  logic [NUM_SIDES-1:0] snap_found;
  logic                 snap_status;
  logic [CW-1:0]        snap_seg [NUM_SIDES][NUM_COORDS];

  class_t                    cls;
  logic                      stall;
  logic                      take_eof;
  logic                      take_seg;
  logic [DIST_BITS-1:0]      seg_dist;
  logic                      nearer;
  logic                      out_load;
  logic                      subtract;
  logic [OUT_COORD_BITS-1:0] out_coord [NUM_COORDS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= SIZE_RESET;
      image_height <= SIZE_RESET;
      side_offset <= OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH: image_width <= cfg_data;
        CFG_HEIGHT: image_height <= cfg_data;
        CFG_OFFSET: side_offset <= cfg_data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // An end of frame may only leave the update stage once the bank is free.
  assign stall = p2_valid && p2_eof && snap_busy;
  assign s_tready = !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (!stall) begin
      p1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      p1_eof <= s_tuser;
      for (int k = 0; k < NUM_COORDS; k++) begin
        p1_seg[k] <= s_tdata[k*IN_COORD_BITS +: CW];
      end
    end
  end

  nel_classify #(
    .CW(CW)
  ) u_classify (
    .sx (p1_seg[0]),
    .sy (p1_seg[1]),
    .ex (p1_seg[2]),
    .ey (p1_seg[3]),
    .cx (image_width[SIZE_BITS-1:1]),
    .cy (image_height[SIZE_BITS-1:1]),
    .res(cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (!stall) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      p2_eof <= p1_eof;
      p2_side <= cls.side;
      p2_sqx <= cls.ddx * cls.ddx;
      p2_sqy <= cls.ddy * cls.ddy;
      p2_seg <= p1_seg;
    end
  end

  assign seg_dist = DIST_BITS'(p2_sqx) + DIST_BITS'(p2_sqy);
  // Strictly nearer only, so an earlier segment wins a tie.
  assign nearer = !found[p2_side] || (seg_dist < best_dist[p2_side]);
  assign take_seg = p2_valid && !p2_eof && nearer;
  assign take_eof = p2_valid && p2_eof && !snap_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= '0;
    end else if (take_eof) begin
      found <= '0;
    end else if (take_seg) begin
      found[p2_side] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_seg) begin
      best_dist[p2_side] <= seg_dist;
      best_seg[p2_side] <= p2_seg;
    end
  end

  // Result bank drained one side per cycle into the output register while the receiver takes results.
  assign out_load = snap_busy && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_busy <= 1'b0;
      side_cnt <= '0;
    end else if (take_eof) begin
      snap_busy <= 1'b1;
      side_cnt <= '0;
    end else if (out_load) begin
      side_cnt <= side_cnt + 2'd1;
      if (side_cnt == SIDE_RIGHT) begin
        snap_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_eof) begin
      snap_found <= found;
      snap_status <= !(&found);
      snap_seg <= best_seg;
    end
  end

  always_comb begin
    subtract = (side_cnt == SIDE_TOP) || (side_cnt == SIDE_RIGHT);
    for (int k = 0; k < NUM_COORDS; k++) begin
      if (!snap_found[side_cnt]) begin
        out_coord[k] = '0;
      end else if (subtract) begin
        out_coord[k] = OUT_COORD_BITS'(snap_seg[side_cnt][k])
                       - OUT_COORD_BITS'(side_offset);
      end else begin
        out_coord[k] = OUT_COORD_BITS'(snap_seg[side_cnt][k])
                       + OUT_COORD_BITS'(side_offset);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {out_coord[3], out_coord[2], out_coord[1], out_coord[0]};
      m_tuser <= {snap_status, side_cnt};
      m_tlast <= (side_cnt == SIDE_RIGHT);
    end
  end

`ifndef SYNTHESIS
  a_last_on_right: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1:0] == SIDE_RIGHT)
    else $error("tlast on a result that is not the right side");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !snap_busy |-> side_cnt == 2'd0)
    else $error("side counter not at top while the result bank is idle");

  a_store_cleared: assert property (@(posedge clk) disable iff (rst)
    take_eof |=> found == '0)
    else $error("store not emptied after end of frame");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !snap_busy)
    else $error("results pending right after reset");
`endif

endmodule
